// File: design/spd_pkg.sv
// package: shared types and constants of the solenoid pulse driver
`default_nettype none
package spd_pkg;

	// operation codes of an input item
	localparam logic [1:0] OP_ENGAGE = 2'd0;
	localparam logic [1:0] OP_REST   = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FORCE_MAX   = 2'd0;
	localparam logic [1:0] REG_FORCE_MIN   = 2'd1;
	localparam logic [1:0] REG_FORCE_SCALE = 2'd2;
	localparam logic [1:0] REG_PULSE_DUR   = 2'd3;

	// field widths
	localparam int FORCE_W = 16;
	localparam int DUR_W   = 18;
	localparam int CFG_W   = 18;
	localparam int IDX_W   = 2;

	// longest accepted pulse duration in ticks
	localparam logic [DUR_W-1:0] TIME_LIMIT = 18'd250000;
	// full scale of force and duty
	localparam logic [FORCE_W-1:0] FULL_SCALE = 16'hFFFF;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul1;
		logic div1;
		logic mul2;
		logic div2;
		logic commit;
	} spd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_calc;
	} spd_status_t;

endpackage
`default_nettype wire

// File: design/spd_if.sv
// interfaces: input item channel and result item channel
`default_nettype none
interface spd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] force_req;

	modport source (output valid, output operation, output force_req, input ready);
	modport sink (input valid, input operation, input force_req, output ready);
endinterface

interface spd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] duty;
	logic        engaged;
	logic        timed_out;

	modport source (output valid, output duty, output engaged, output timed_out, input ready);
	modport sink (input valid, input duty, input engaged, input timed_out, output ready);
endinterface
`default_nettype wire

// File: design/spd_ctrl.sv
// controller: sequences the duty computation and the result handoff
`default_nettype none
module spd_ctrl
	import spd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire spd_status_t status,
	output spd_cmd_t         cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL1 = 6'b000010,
		ST_DIV1 = 6'b000100,
		ST_MUL2 = 6'b001000,
		ST_DIV2 = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = status.need_calc ? ST_MUL1 : ST_FIN;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div2 = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/spd_datapath.sv
// datapath: config registers, shared multiplier, divide by full scale, pulse state
`default_nettype none
module spd_datapath
	import spd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic [1:0]         in_operation,
	input  wire logic [FORCE_W-1:0] in_force_req,
	input  wire spd_cmd_t           cmd,
	output spd_status_t             status,
	output logic [FORCE_W-1:0]      duty,
	output logic                    engaged,
	output logic                    timed_out
);

	// floor(x / 65535) by shift estimate and one correction
	function automatic logic [FORCE_W-1:0] div_fs(input logic [2*FORCE_W-1:0] x);
		logic [FORCE_W-1:0] q0;
		logic [FORCE_W:0]   r0;
		q0 = x[2*FORCE_W-1:FORCE_W];
		r0 = {1'b0, x[FORCE_W-1:0]} + {1'b0, q0};
		return q0 + {{(FORCE_W-1){1'b0}}, (r0 >= {1'b0, FULL_SCALE})};
	endfunction

	logic [FORCE_W-1:0]   force_max_q, force_min_q, force_scale_q;
	logic [DUR_W-1:0]     pulse_dur_q;
	logic [1:0]           op_q;
	logic [FORCE_W-1:0]   force_q;
	logic [2*FORCE_W-1:0] prod_q;
	logic [FORCE_W-1:0]   a_q;
	logic [FORCE_W-1:0]   calc_duty_q;
	logic [DUR_W-1:0]     elapsed_q;
	logic [FORCE_W-1:0]   duty_q;
	logic                 engaged_q;
	logic                 timed_out_q;

	logic [FORCE_W-1:0]   span;
	logic [FORCE_W-1:0]   mul_a, mul_b;
	logic [FORCE_W-1:0]   b_div;
	logic [FORCE_W:0]     duty_sum;
	logic [DUR_W:0]       elapsed_next;

	assign status.need_calc = (in_operation == OP_ENGAGE) && (in_force_req != '0);

	// span clamps at zero when max is below min
	assign span  = (force_max_q > force_min_q) ? (force_max_q - force_min_q) : '0;
	assign mul_a = cmd.mul2 ? span : force_q;
	assign mul_b = cmd.mul2 ? a_q : force_scale_q;
	assign b_div = div_fs(prod_q);
	assign duty_sum = {1'b0, force_min_q} + {1'b0, b_div};
	assign elapsed_next = {1'b0, elapsed_q} + {{DUR_W{1'b0}}, 1'b1};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_max_q   <= FULL_SCALE;
			force_min_q   <= '0;
			force_scale_q <= FULL_SCALE;
			pulse_dur_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORCE_MAX:   force_max_q   <= cfg_data[FORCE_W-1:0];
				REG_FORCE_MIN:   force_min_q   <= cfg_data[FORCE_W-1:0];
				REG_FORCE_SCALE: force_scale_q <= cfg_data[FORCE_W-1:0];
				REG_PULSE_DUR: begin
					if (cfg_data[DUR_W-1:0] <= TIME_LIMIT) begin
						pulse_dur_q <= cfg_data[DUR_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// item latch and duty computation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_operation;
			force_q <= in_force_req;
		end
		if (cmd.mul1 || cmd.mul2) begin
			prod_q <= {{FORCE_W{1'b0}}, mul_a} * {{FORCE_W{1'b0}}, mul_b};
		end
		if (cmd.div1) begin
			a_q <= div_fs(prod_q);
		end
		if (cmd.div2) begin
			calc_duty_q <= duty_sum[FORCE_W] ? FULL_SCALE : duty_sum[FORCE_W-1:0];
		end
	end

	// pulse state and result registers, updated when the item commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			duty_q      <= '0;
			engaged_q   <= 1'b0;
			timed_out_q <= 1'b0;
		end else if (cmd.commit) begin
			timed_out_q <= 1'b0;
			case (op_q)
				OP_ENGAGE: begin
					if (force_q != '0) begin
						duty_q    <= calc_duty_q;
						elapsed_q <= '0;
						engaged_q <= 1'b1;
					end
				end
				OP_REST: begin
					duty_q    <= '0;
					engaged_q <= 1'b0;
				end
				OP_TICK: begin
					if (engaged_q) begin
						if (pulse_dur_q != '0 && elapsed_next > {1'b0, pulse_dur_q}) begin
							duty_q      <= '0;
							engaged_q   <= 1'b0;
							timed_out_q <= 1'b1;
						end else if (elapsed_next[DUR_W]) begin
							elapsed_q <= '1;
						end else begin
							elapsed_q <= elapsed_next[DUR_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign duty      = duty_q;
	assign engaged   = engaged_q;
	assign timed_out = timed_out_q;

endmodule
`default_nettype wire

// File: design/solenoid_pulse_driver.sv
// top level: solenoid one-shot pulse driver
//
// Takes engage, rest and one-microsecond tick items and returns one result item
// per input item with the duty, the engaged flag and a timeout mark for the tick
// that ended the pulse. An engage with a nonzero force passes, after acceptance,
// twice through the shared 16x16 multiplier, each pass followed by a divide by
// 65535, and then through the commit step that registers its result. Rest, tick
// and ignored items go from acceptance straight to the commit step. No new item is
// taken until the current one has committed. A new item is taken while the
// previous result still waits at the output register; it then holds in its commit
// step until that result is taken. Configuration is written through cfg_we,
// cfg_index and cfg_data.
`default_nettype none
module solenoid_pulse_driver
	import spd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	spd_in_if.sink                in_ch,
	spd_out_if.source             out_ch,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	spd_cmd_t    cmd;
	spd_status_t status;

	// control
	spd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	spd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_operation (in_ch.operation),
		.in_force_req (in_ch.force_req),
		.cmd          (cmd),
		.status       (status),
		.duty         (out_ch.duty),
		.engaged      (out_ch.engaged),
		.timed_out    (out_ch.timed_out)
	);

	// a timeout result reports a released solenoid
	a_timeout_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.timed_out |-> !out_ch.engaged && out_ch.duty == '0)
		else $error("timeout result still engaged");

	// released solenoid carries zero duty
	a_released_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.engaged |-> out_ch.duty == '0)
		else $error("released result with nonzero duty");

	// an accepted item leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("ready held after accepting an item");

endmodule
`default_nettype wire

// File: verif/solenoid_pulse_driver_test.sv
// testbench: solenoid pulse driver checked item by item against a cycle-free predictor
`timescale 1ns / 100ps
module solenoid_pulse_driver_test
	import spd_pkg::*;
();

	localparam int CLK_PERIOD  = 12;
	localparam int RESET_CYCLES = 7;
	localparam int MAX_IDLE    = 18;
	localparam int LONG_HOLD   = 300;
	localparam int IDLE_PAD    = 8;
	localparam int END_PAD     = 20;
	localparam int NUM_PHASES  = 13;
	localparam int PHASE_ITEMS = 100;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [DUR_W-1:0] COUNT_CAP = 18'h3FFFF;
	// operation code with no meaning, ignored by the block
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	// one result item
	typedef struct packed {
		logic [FORCE_W-1:0] duty;
		logic               engaged;
		logic               timed_out;
	} drive_t;

	// result typed into the directed table, if any
	typedef struct {
		bit     typed;
		drive_t want;
	} typed_drive_t;

	typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [1:0]         code;
		logic [CFG_W-1:0]   value;
		bit                 typed;
		drive_t             want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	spd_in_if  in_ch();
	spd_out_if out_ch();

	solenoid_pulse_driver DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predictor state and registers, at their reset values
	logic [FORCE_W-1:0] shadow_max     = FULL_SCALE;
	logic [FORCE_W-1:0] shadow_min     = '0;
	logic [FORCE_W-1:0] shadow_scale   = FULL_SCALE;
	logic [DUR_W-1:0]   shadow_dur     = '0;
	logic [FORCE_W-1:0] shadow_duty    = '0;
	logic               shadow_engaged = 1'b0;
	logic [DUR_W-1:0]   shadow_elapsed = '0;

	drive_t       awaited_drive_q[$];
	typed_drive_t typed_drive_q[$];
	stim_row_t    stim_table[$];

	int mismatches = 0;
	int tx_gap_max = MAX_IDLE;
	int rx_stall_max = MAX_IDLE;
	bit long_hold = 1'b0;

	// force scaled twice over full scale, offset by the minimum
	function automatic logic [FORCE_W-1:0] scaled_duty(input logic [FORCE_W-1:0] f);
		logic [31:0]        prod;
		logic [FORCE_W-1:0] a;
		logic [FORCE_W-1:0] span;
		logic [FORCE_W-1:0] b;
		logic [FORCE_W:0]   sum;
		prod = 32'(f) * 32'(shadow_scale);
		a = FORCE_W'(prod / 32'(FULL_SCALE));
		span = (shadow_max > shadow_min) ? shadow_max - shadow_min : '0;
		prod = 32'(span) * 32'(a);
		b = FORCE_W'(prod / 32'(FULL_SCALE));
		sum = {1'b0, shadow_min} + {1'b0, b};
		return (sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : sum[FORCE_W-1:0];
	endfunction

	// advance the predictor by one input item
	task automatic step_drive(input logic [1:0] op, input logic [FORCE_W-1:0] f,
			output drive_t r);
		logic [DUR_W:0] nxt;
		r.timed_out = 1'b0;
		case (op)
			OP_ENGAGE: begin
				if (f != '0) begin
					shadow_duty = scaled_duty(f);
					shadow_elapsed = '0;
					shadow_engaged = 1'b1;
				end
			end
			OP_REST: begin
				shadow_duty = '0;
				shadow_engaged = 1'b0;
			end
			OP_TICK: begin
				if (shadow_engaged) begin
					nxt = {1'b0, shadow_elapsed} + {{DUR_W{1'b0}}, 1'b1};
					if (shadow_dur != '0 && nxt > {1'b0, shadow_dur}) begin
						shadow_duty = '0;
						shadow_engaged = 1'b0;
						r.timed_out = 1'b1;
					end else begin
						shadow_elapsed = (nxt > {1'b0, COUNT_CAP}) ? COUNT_CAP :
							nxt[DUR_W-1:0];
					end
				end
			end
			default: ;
		endcase
		r.duty = shadow_duty;
		r.engaged = shadow_engaged;
	endtask

	// register write as the predictor sees it
	task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		case (idx)
			REG_FORCE_MAX:   shadow_max = data[FORCE_W-1:0];
			REG_FORCE_MIN:   shadow_min = data[FORCE_W-1:0];
			REG_FORCE_SCALE: shadow_scale = data[FORCE_W-1:0];
			REG_PULSE_DUR: begin
				if (data <= TIME_LIMIT) shadow_dur = data;
			end
			default: ;
		endcase
	endtask

	// scoreboard: predict on input accept, compare on output accept
	always @(posedge clk) begin : scoreboard
		drive_t       want;
		drive_t       got;
		typed_drive_t ov;
		if (cfg_we) apply_reg(cfg_index, cfg_data);
		if (in_ch.valid && in_ch.ready) begin
			step_drive(in_ch.operation, in_ch.force_req, want);
			ov = typed_drive_q.pop_front();
			if (ov.typed) want = ov.want;
			awaited_drive_q = {awaited_drive_q, want};
		end
		if (out_ch.valid && out_ch.ready) begin
			got.duty = out_ch.duty;
			got.engaged = out_ch.engaged;
			got.timed_out = out_ch.timed_out;
			if (awaited_drive_q.size() == 0) begin
				$error("result item with nothing awaited: duty %0d engaged %0d timed_out %0d",
					got.duty, got.engaged, got.timed_out);
				mismatches++;
			end else begin
				want = awaited_drive_q.pop_front();
				if (got.duty !== want.duty) begin
					$error("duty: expected %0d, got %0d", want.duty, got.duty);
					mismatches++;
				end
				if (got.engaged !== want.engaged) begin
					$error("engaged: expected %0d, got %0d", want.engaged, got.engaged);
					mismatches++;
				end
				if (got.timed_out !== want.timed_out) begin
					$error("timed_out: expected %0d, got %0d", want.timed_out, got.timed_out);
					mismatches++;
				end
			end
		end
	end

	// result receiver: random stalls, one long hold-off on request
	initial begin : receiver
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				stall = LONG_HOLD;
				long_hold = 1'b0;
			end else begin
				stall = $urandom_range(0, rx_stall_max);
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// run ends here if the block hangs
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("solenoid_pulse_driver_test failed");
		$finish;
	end

	// offer one input item after a random gap
	task automatic send_item(input logic [1:0] op, input logic [FORCE_W-1:0] f,
			input bit typed, input drive_t want);
		int           gap;
		typed_drive_t ov;
		gap = $urandom_range(0, tx_gap_max);
		ov.typed = typed;
		ov.want = want;
		typed_drive_q = {typed_drive_q, ov};
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.force_req <= f;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// stop offering until every awaited result has come
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_drive_q.size() != 0);
	endtask

	task automatic wait_idle();
		drain_results();
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_item(input logic [1:0] op, input logic [FORCE_W-1:0] f, input bit typed,
			input logic [FORCE_W-1:0] duty, input bit eng, input bit to);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.code = op;
		row.value = CFG_W'(f);
		row.typed = typed;
		row.want.duty = duty;
		row.want.engaged = eng;
		row.want.timed_out = to;
		stim_table = {stim_table, row};
	endtask

	task automatic add_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		stim_row_t row;
		row.kind = ROW_REG;
		row.code = idx;
		row.value = data;
		row.typed = 1'b0;
		row.want = '0;
		stim_table = {stim_table, row};
	endtask

	function automatic logic [FORCE_W-1:0] pick_level();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return FULL_SCALE;
			default: return FORCE_W'($urandom);
		endcase
	endfunction

	function automatic logic [FORCE_W-1:0] pick_force();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 16'd1;
			2: return FULL_SCALE;
			default: return FORCE_W'($urandom);
		endcase
	endfunction

	// mostly short pulses, sometimes held, longest, or out of range
	function automatic logic [CFG_W-1:0] pick_duration();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return TIME_LIMIT;
			2: return CFG_W'($urandom_range(int'(TIME_LIMIT) + 1, int'(COUNT_CAP)));
			default: return CFG_W'($urandom_range(1, 24));
		endcase
	endfunction

	// one random phase: new settings, then mostly engage-tick pulses
	task automatic run_phase(input int phase);
		int         live;
		int         k;
		bit         paused;
		logic [1:0] op;
		logic [FORCE_W-1:0] f;
		live = 0;
		paused = 1'b0;
		wait_idle();
		write_reg(REG_FORCE_MAX, CFG_W'(pick_level()));
		write_reg(REG_FORCE_MIN, ($urandom_range(0, 3) == 0) ? CFG_W'(pick_level()) :
			CFG_W'($urandom_range(0, 8000)));
		write_reg(REG_FORCE_SCALE, CFG_W'(pick_level()));
		write_reg(REG_PULSE_DUR, pick_duration());
		tx_gap_max = (phase % 3 == 0) ? 0 : MAX_IDLE;
		rx_stall_max = (phase % 4 == 1) ? 0 : MAX_IDLE;
		// back-to-back items against a held-off receiver
		if (phase == 2) begin
			tx_gap_max = 0;
			long_hold = 1'b1;
		end
		while (live < PHASE_ITEMS) begin
			if (phase == 7 && !paused && live >= PHASE_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					f = pick_force();
					send_item(OP_ENGAGE, f, 1'b0, '0);
					if (f != '0) live++;
					if (shadow_dur != '0 && shadow_dur < 40)
						k = $urandom_range(0, int'(shadow_dur) + 3);
					else
						k = $urandom_range(0, 30);
					repeat (k) begin
						send_item(OP_TICK, FORCE_W'($urandom), 1'b0, '0);
						live++;
					end
					if ($urandom_range(0, 3) == 0) begin
						send_item(OP_REST, FORCE_W'($urandom), 1'b0, '0);
						live++;
					end
				end
				6, 7: begin
					send_item(OP_REST, FORCE_W'($urandom), 1'b0, '0);
					live++;
				end
				8: begin
					op = 2'($urandom);
					f = FORCE_W'($urandom);
					send_item(op, f, 1'b0, '0);
					if (op != OP_ENGAGE && op != OP_REST && op != OP_TICK) ;
					else live++;
				end
				default: begin
					repeat ($urandom_range(1, 4)) begin
						send_item(OP_TICK, FORCE_W'($urandom), 1'b0, '0);
						live++;
					end
				end
			endcase
		end
	endtask

	// main sequence: reset, directed table, random phases, drain, verdict
	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FORCE_MAX;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= OP_TICK;
		in_ch.force_req <= '0;

		// defaults after reset: full span, unity scale, held pulse
		add_item(OP_TICK,    16'd0,     1'b1, 16'd0,     1'b0, 1'b0);
		add_item(OP_ENGAGE,  16'd0,     1'b1, 16'd0,     1'b0, 1'b0);
		add_item(OP_ENGAGE,  16'hFFFF,  1'b1, 16'hFFFF,  1'b1, 1'b0);
		add_item(OP_TICK,    16'd0,     1'b1, 16'hFFFF,  1'b1, 1'b0);
		add_item(OP_UNKNOWN, 16'hFFFF,  1'b1, 16'hFFFF,  1'b1, 1'b0);
		add_item(OP_ENGAGE,  16'd1,     1'b1, 16'd1,     1'b1, 1'b0);
		add_item(OP_REST,    16'hFFFF,  1'b1, 16'd0,     1'b0, 1'b0);
		// two-tick pulse times out on the third tick
		add_reg(REG_PULSE_DUR, 18'd2);
		add_item(OP_ENGAGE, 16'hFFFF,  1'b1, 16'hFFFF,  1'b1, 1'b0);
		add_item(OP_TICK,   16'd0,     1'b1, 16'hFFFF,  1'b1, 1'b0);
		add_item(OP_TICK,   16'd0,     1'b1, 16'hFFFF,  1'b1, 1'b0);
		add_item(OP_TICK,   16'd0,     1'b1, 16'd0,     1'b0, 1'b1);
		add_item(OP_TICK,   16'd0,     1'b1, 16'd0,     1'b0, 1'b0);
		// duration above the limit leaves the old one in place
		add_reg(REG_PULSE_DUR, COUNT_CAP);
		add_item(OP_ENGAGE, 16'd30000, 1'b1, 16'd30000, 1'b1, 1'b0);
		add_item(OP_TICK,   16'd0,     1'b1, 16'd30000, 1'b1, 1'b0);
		add_item(OP_TICK,   16'd0,     1'b1, 16'd30000, 1'b1, 1'b0);
		add_item(OP_TICK,   16'd0,     1'b1, 16'd0,     1'b0, 1'b1);
		// max below min: no span, duty is the minimum
		add_reg(REG_FORCE_MAX, 18'd100);
		add_reg(REG_FORCE_MIN, 18'd200);
		add_item(OP_ENGAGE, 16'd40000, 1'b1, 16'd200,   1'b1, 1'b0);
		// zero scale at top minimum
		add_reg(REG_FORCE_SCALE, 18'd0);
		add_reg(REG_FORCE_MAX, 18'hFFFF);
		add_reg(REG_FORCE_MIN, 18'hFFFF);
		add_item(OP_ENGAGE, 16'd12345, 1'b1, 16'hFFFF,  1'b1, 1'b0);
		// zero span with zero minimum: engaged at duty zero
		add_reg(REG_PULSE_DUR, TIME_LIMIT);
		add_reg(REG_FORCE_MIN, 18'd0);
		add_reg(REG_FORCE_SCALE, 18'hFFFF);
		add_reg(REG_FORCE_MAX, 18'd0);
		add_item(OP_ENGAGE, 16'hFFFF,  1'b1, 16'd0,     1'b1, 1'b0);
		// mid-range settings left to the predictor
		add_reg(REG_FORCE_MAX, 18'd60000);
		add_reg(REG_FORCE_MIN, 18'd1000);
		add_reg(REG_FORCE_SCALE, 18'd32768);
		add_item(OP_ENGAGE, 16'd50000, 1'b0, 16'd0, 1'b0, 1'b0);
		add_item(OP_TICK,   16'd0,     1'b0, 16'd0, 1'b0, 1'b0);
		add_item(OP_ENGAGE, 16'd0,     1'b0, 16'd0, 1'b0, 1'b0);
		add_item(OP_REST,   16'd0,     1'b0, 16'd0, 1'b0, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(stim_table[i].code, stim_table[i].value);
			end else begin
				send_item(stim_table[i].code, stim_table[i].value[FORCE_W-1:0],
					stim_table[i].typed, stim_table[i].want);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) run_phase(p);

		drain_results();
		repeat (END_PAD) @(posedge clk);
		if (mismatches == 0 && awaited_drive_q.size() == 0)
			$display("solenoid_pulse_driver_test passed");
		else
			$display("solenoid_pulse_driver_test failed");
		$finish;
	end

endmodule

// File: files.f
design/spd_pkg.sv
design/spd_if.sv
design/spd_ctrl.sv
design/spd_datapath.sv
design/solenoid_pulse_driver.sv
verif/solenoid_pulse_driver_test.sv
